FILE: hdl/rsst_pkg.sv
// Shared types and constants for the range-add / range-sum block.
// No dependencies; used by rsst_ctrl, the top level and rsst_check.
package rsst_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int LEN_W     = 11;
    localparam int IDX_W     = 12;
    localparam int ADDR_W    = 10;
    localparam int SUM_W     = 64;
    localparam int VAL_W     = 32;
    localparam int WORD_W    = 2 * SUM_W;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN);

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } res_t;

endpackage

FILE: hdl/rsst_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rsst_ram #(
    parameter int DATA_W = 128,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/rsst_ctrl.sv
// Sequencer: two binary indexed trees in one RAM word, walked node by node.
// Depends on rsst_pkg and rsst_ram.
module rsst_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear_req,
    input  logic [rsst_pkg::LEN_W-1:0]  length,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  op,
    input  logic [rsst_pkg::LEN_W-1:0]  range_low,
    input  logic [rsst_pkg::LEN_W-1:0]  range_high,
    input  logic [rsst_pkg::VAL_W-1:0]  add_value,
    input  logic                        res_free,
    output rsst_pkg::res_t              res
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DEC   = 13'b0000000000010,
        S_CLR   = 13'b0000000000100,
        S_USET  = 13'b0000000001000,
        S_UMUL  = 13'b0000000010000,
        S_URD   = 13'b0000000100000,
        S_UWR   = 13'b0000001000000,
        S_QSET  = 13'b0000010000000,
        S_QRD   = 13'b0000100000000,
        S_QACC  = 13'b0001000000000,
        S_QMUL  = 13'b0010000000000,
        S_QFIN  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      op_reg;
    logic [rsst_pkg::LEN_W-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [rsst_pkg::VAL_W-1:0]      val_reg;
    logic [rsst_pkg::LEN_W-1:0]      p_reg, p_next;
    logic [rsst_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                            ph_reg, ph_next;
    logic [rsst_pkg::ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [rsst_pkg::SUM_W-1:0]      d1_reg, d1_next, d2_reg, d2_next;
    logic [rsst_pkg::SUM_W-1:0]      s1_reg, s1_next, s2_reg, s2_next;
    logic [rsst_pkg::SUM_W-1:0]      prod_reg, prod_next, tot_reg, tot_next;

    logic                            ram_we, ram_re;
    logic [rsst_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [rsst_pkg::WORD_W-1:0]     ram_wdata, ram_rdata;
    logic [rsst_pkg::SUM_W-1:0]      rd_b1, rd_b2;

    logic [rsst_pkg::IDX_W-1:0]      lowbit;
    logic [rsst_pkg::LEN_W-1:0]      lo_clamp, hi_clamp;
    logic [rsst_pkg::SUM_W-1:0]      v_ext, pre_val;
    logic signed [44:0]              dprod;
    logic [74:0]                     qprod;

    rsst_ram #(
        .DATA_W (rsst_pkg::WORD_W),
        .ADDR_W (rsst_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_b1      = ram_rdata[rsst_pkg::WORD_W-1:rsst_pkg::SUM_W];
    assign rd_b2      = ram_rdata[rsst_pkg::SUM_W-1:0];
    assign lowbit     = idx_reg & (~idx_reg + rsst_pkg::IDX_W'(1));
    assign item_stall = (state_reg != S_IDLE);
    assign v_ext      = {{(rsst_pkg::SUM_W-rsst_pkg::VAL_W){val_reg[rsst_pkg::VAL_W-1]}},
                         val_reg};
    assign dprod      = $signed(d1_reg[32:0]) * $signed({1'b0, p_reg});
    assign qprod      = s1_reg * p_reg;
    assign pre_val    = prod_reg - s2_reg;

    // Interval clipped to 1..length
    assign lo_clamp = (lo_reg == '0) ? rsst_pkg::LEN_W'(1) : lo_reg;
    assign hi_clamp = (hi_reg > length) ? length : hi_reg;

    // RAM port drive
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = idx_reg[rsst_pkg::ADDR_W-1:0];
        ram_raddr = idx_reg[rsst_pkg::ADDR_W-1:0];
        ram_wdata = {rd_b1 + d1_reg, rd_b2 + d2_reg};
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
            end
            S_URD:  ram_re = (idx_reg <= rsst_pkg::IDX_MAX);
            S_UWR:  ram_we = 1'b1;
            S_QRD:  ram_re = (idx_reg != '0);
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        p_next     = p_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        cnt_next   = cnt_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        prod_next  = prod_reg;
        tot_next   = tot_reg;
        res.valid  = 1'b0;
        res.sum    = tot_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                lo_next  = lo_clamp;
                hi_next  = hi_clamp;
                ph_next  = 1'b0;
                tot_next = '0;
                cnt_next = '0;
                case (op_reg)
                    rsst_pkg::OP_ADD:
                        state_next = (lo_clamp <= hi_clamp) ? S_USET : S_IDLE;
                    rsst_pkg::OP_QUERY:
                        state_next = (lo_clamp <= hi_clamp) ? S_QSET : S_DONE;
                    rsst_pkg::OP_CLEAR:
                        state_next = S_CLR;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_CLR:
            begin
                cnt_next = cnt_reg + rsst_pkg::ADDR_W'(1);
                if (cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            // Point update at lo with +v, then at hi+1 with -v
            S_USET:
            begin
                if (ph_reg)
                begin
                    idx_next = rsst_pkg::IDX_W'(hi_reg) + rsst_pkg::IDX_W'(1);
                    d1_next  = '0 - v_ext;
                    p_next   = hi_reg;
                end
                else
                begin
                    idx_next = rsst_pkg::IDX_W'(lo_reg);
                    d1_next  = v_ext;
                    p_next   = lo_reg - rsst_pkg::LEN_W'(1);
                end
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                d2_next    = {{(rsst_pkg::SUM_W-45){dprod[44]}}, dprod};
                state_next = S_URD;
            end
            S_URD:
            begin
                if (idx_reg <= rsst_pkg::IDX_MAX)
                begin
                    state_next = S_UWR;
                end
                else if (ph_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ph_next    = 1'b1;
                    state_next = S_USET;
                end
            end
            S_UWR:
            begin
                idx_next   = idx_reg + lowbit;
                state_next = S_URD;
            end
            // Prefix sum at hi, then at lo-1
            S_QSET:
            begin
                p_next     = ph_reg ? (lo_reg - rsst_pkg::LEN_W'(1)) : hi_reg;
                idx_next   = ph_reg ? rsst_pkg::IDX_W'(lo_reg - rsst_pkg::LEN_W'(1))
                                    : rsst_pkg::IDX_W'(hi_reg);
                s1_next    = '0;
                s2_next    = '0;
                state_next = S_QRD;
            end
            S_QRD:
            begin
                state_next = (idx_reg != '0) ? S_QACC : S_QMUL;
            end
            S_QACC:
            begin
                s1_next    = s1_reg + rd_b1;
                s2_next    = s2_reg + rd_b2;
                idx_next   = idx_reg - lowbit;
                state_next = S_QRD;
            end
            S_QMUL:
            begin
                prod_next  = qprod[rsst_pkg::SUM_W-1:0];
                state_next = S_QFIN;
            end
            S_QFIN:
            begin
                if (ph_reg)
                begin
                    tot_next   = tot_reg - pre_val;
                    state_next = S_DONE;
                end
                else
                begin
                    tot_next   = pre_val;
                    ph_next    = 1'b1;
                    state_next = S_QSET;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Length write restarts the clearing sweep
        if (clear_req)
        begin
            state_next = S_CLR;
            cnt_next   = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ph_reg    <= ph_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
        begin
            op_reg  <= op;
            lo_reg  <= range_low;
            hi_reg  <= range_high;
            val_reg <= add_value;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        p_reg    <= p_next;
        idx_reg  <= idx_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        prod_reg <= prod_next;
        tot_reg  <= tot_next;
    end

endmodule

FILE: hdl/range_add_range_sum_tree.sv
// Top level: length register, sequencer and result register.
// Depends on rsst_pkg and rsst_ctrl.
//
// Range add / range sum over elements 1..active_length (signed 64-bit,
// wrapping). Input words (op, range_low, range_high, add_value) are taken
// on item_valid with item_stall low; op 0 adds, op 1 queries, op 2 clears.
// Only queries give a result word on range_sum with result_valid; the
// receiver holds it with result_stall, and a finished sum waits in the
// output register while the next word is accepted.
// A word on the config channel (cfg_valid/cfg_ready, always ready) sets
// active_length (0 taken as 1, above 1024 as 1024) and clears all elements.
// The elements live in two binary indexed trees sharing one 1024 x 128 RAM
// with a registered read; on an add each tree node is a read then a write,
// on a query a read then an accumulate. One item at a time. A clear, a
// length write and reset each start a sweep of all 1024 RAM words during
// which item_stall is high.
// Reset sets active_length to 1024 and empties the result register.
module range_add_range_sum_tree (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rsst_pkg::LEN_W-1:0]  active_length,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  op,
    input  logic [rsst_pkg::LEN_W-1:0]  range_low,
    input  logic [rsst_pkg::LEN_W-1:0]  range_high,
    input  logic [rsst_pkg::VAL_W-1:0]  add_value,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [rsst_pkg::SUM_W-1:0]  range_sum
);

    logic [rsst_pkg::LEN_W-1:0] len_reg, len_next;
    logic                       valid_reg;
    logic [rsst_pkg::SUM_W-1:0] sum_reg;
    logic                       cfg_wr, res_free;
    rsst_pkg::res_t             res;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid;
    assign res_free     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign range_sum    = sum_reg;

    // Saturate the written length to 1..MAX_LEN
    always_comb
    begin
        if (active_length == '0)
        begin
            len_next = rsst_pkg::LEN_W'(1);
        end
        else if (active_length > rsst_pkg::LEN_MAX)
        begin
            len_next = rsst_pkg::LEN_MAX;
        end
        else
        begin
            len_next = active_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= rsst_pkg::LEN_MAX;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                len_reg <= len_next;
            end
            if (res.valid)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            sum_reg <= res.sum;
        end
    end

    rsst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_req  (cfg_wr),
        .length     (len_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .range_low  (range_low),
        .range_high (range_high),
        .add_value  (add_value),
        .res_free   (res_free),
        .res        (res)
    );

endmodule

FILE: hdl/rsst_check.sv
// Port-level checks for range_add_range_sum_tree, with its bind.
// Depends on rsst_pkg and the top level.
module rsst_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic                        item_valid,
    input logic                        item_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [rsst_pkg::SUM_W-1:0]  range_sum
);

    // A stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(range_sum))
        else $error("result word changed under stall");

    // One item at a time: busy right after accepting
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken twice in a row");

    // A length write starts the clearing sweep
    a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> item_stall)
        else $error("input open right after length write");

endmodule

bind range_add_range_sum_tree rsst_check u_rsst_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .range_sum    (range_sum)
);

FILE: test/testbench.sv
// Self-checking testbench for range_add_range_sum_tree: directed table, then
// random phases. Depends on rsst_pkg and the block's RTL in hdl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rsst_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASE_WORDS  = 92;

    typedef struct {
        logic [1:0]       code;
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
        logic [VAL_W-1:0] val;
        bit               known;
        logic [SUM_W-1:0] sum;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   active_length = '0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [1:0]         op = OP_ADD;
    logic [LEN_W-1:0]   range_low = '0;
    logic [LEN_W-1:0]   range_high = '0;
    logic [VAL_W-1:0]   add_value = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [SUM_W-1:0]   range_sum;

    // predictor state: flat element array and current length
    logic [SUM_W-1:0]   elem_model [1:MAX_LEN];
    int                 len_model;
    logic [SUM_W-1:0]   sum_q [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 tx_pct = 0;
    int                 rx_pct = 0;
    int                 hold_req = 0;
    int                 hold_cnt = 0;
    stim_row_t          rows [$];

    range_add_range_sum_tree i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .active_length (active_length),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .range_low     (range_low),
        .range_high    (range_high),
        .add_value     (add_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .range_sum     (range_sum)
    );

    always #2 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [SUM_W-1:0] want,
                                   logic [SUM_W-1:0] got);
        $display("ERROR %s: expected %h got %h", what, want, got);
        errors++;
    endtask

    task automatic clear_model();
        for (int i = 1; i <= MAX_LEN; i++)
            elem_model[i] = '0;
    endtask

    function automatic logic [SUM_W-1:0] interval_sum(int lo, int hi);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int i = (lo < 1 ? 1 : lo); i <= hi && i <= len_model; i++)
            acc += elem_model[i];
        return acc;
    endfunction

    // apply one accepted word to the predictor
    task automatic predict_word(stim_row_t w);
        logic [SUM_W-1:0] s;
        case (w.code)
            OP_ADD:
                for (int i = (w.lo < 1 ? 1 : int'(w.lo)); i <= w.hi && i <= len_model; i++)
                    elem_model[i] += {{(SUM_W-VAL_W){w.val[VAL_W-1]}}, w.val};
            OP_QUERY:
            begin
                s = interval_sum(w.lo, w.hi);
                if (w.known && s !== w.sum)
                    report_mismatch("directed row", w.sum, s);
                sum_q.push_back(s);
            end
            OP_CLEAR:
                clear_model();
            default: ;
        endcase
    endtask

    // starts and ends at a falling edge
    task automatic send_word(stim_row_t w);
        while ($urandom_range(99) < tx_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        op         <= w.code;
        range_low  <= w.lo;
        range_high <= w.hi;
        add_value  <= w.val;
        do
            @(posedge clk);
        while (item_stall);
        predict_word(w);
        @(negedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        int n;
        cfg_valid     <= 1'b1;
        active_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        n = (v == 0) ? 1 : (v > MAX_LEN ? MAX_LEN : int'(v));
        len_model = n;
        clear_model();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t random_word();
        stim_row_t w;
        int r;
        int a;
        int b;
        r = $urandom_range(99);
        w.code = (r < 46) ? OP_ADD : (r < 94) ? OP_QUERY : (r < 97) ? OP_CLEAR : 2'd3;
        if ($urandom_range(9) == 0)
        begin
            a = $urandom_range(2047);
            b = $urandom_range(2047);
        end
        else
        begin
            a = $urandom_range(len_model, 1);
            b = $urandom_range(len_model, 1);
            if (a > b && $urandom_range(7) != 0)
            begin
                r = a; a = b; b = r;
            end
        end
        w.lo = LEN_W'(a);
        w.hi = LEN_W'(b);
        w.val = ($urandom_range(1) == 0) ? $urandom() : VAL_W'($urandom_range(200) - 100);
        w.known = 1'b0;
        w.sum = '0;
        return w;
    endfunction

    // result side: random stall plus a long counted hold on request
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < rx_pct);
    end

    // compare every accepted result word with the oldest expected sum
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (sum_q.size() == 0)
            begin
                $display("ERROR unexpected result word %h", range_sum);
                errors++;
            end
            else
            begin
                if (range_sum !== sum_q[0])
                    report_mismatch("range_sum", sum_q[0], range_sum);
                void'(sum_q.pop_front());
            end
        end
    end

    function automatic stim_row_t mk(logic [1:0] c, int lo, int hi,
                                     logic [VAL_W-1:0] v, bit k, logic [SUM_W-1:0] s);
        stim_row_t w;
        w.code = c; w.lo = LEN_W'(lo); w.hi = LEN_W'(hi); w.val = v; w.known = k; w.sum = s;
        return w;
    endfunction

    initial
    begin
        logic [LEN_W-1:0] lens [6];
        len_model = MAX_LEN;
        clear_model();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at the reset length
        rows.push_back(mk(OP_QUERY, 1, 1024, 0, 1, 64'd0));
        rows.push_back(mk(OP_ADD, 1, 1024, 32'h7fffffff, 0, 0));
        rows.push_back(mk(OP_QUERY, 1, 1024, 0, 1, 64'd1024 * 64'h7fffffff));
        rows.push_back(mk(OP_ADD, 1, 1, 32'h80000000, 0, 0));
        rows.push_back(mk(OP_ADD, 1024, 1024, 32'hffffffff, 0, 0));
        rows.push_back(mk(OP_QUERY, 1, 1, 0, 1, 64'hffffffffffffffff));
        rows.push_back(mk(OP_QUERY, 1024, 1024, 0, 1, 64'h7ffffffe));
        rows.push_back(mk(OP_QUERY, 5, 4, 0, 1, 64'd0));
        rows.push_back(mk(OP_QUERY, 0, 0, 0, 1, 64'd0));
        rows.push_back(mk(OP_QUERY, 1025, 2047, 0, 1, 64'd0));
        rows.push_back(mk(OP_ADD, 0, 2047, 32'd3, 0, 0));
        rows.push_back(mk(OP_ADD, 9, 8, 32'd77, 0, 0));
        rows.push_back(mk(2'd3, 1, 1024, 32'd5, 0, 0));
        rows.push_back(mk(OP_QUERY, 0, 2047, 0, 0, 0));
        rows.push_back(mk(OP_QUERY, 300, 700, 0, 0, 0));
        rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0));
        rows.push_back(mk(OP_QUERY, 1, 1024, 0, 1, 64'd0));
        rows.push_back(mk(OP_ADD, 512, 513, 32'h12345678, 0, 0));
        rows.push_back(mk(OP_QUERY, 513, 1024, 0, 0, 0));
        foreach (rows[i])
            send_word(rows[i]);
        item_valid <= 1'b0;

        // random phases, each writing its own length, with the idle mix set per pair of phases
        lens[0] = 11'd0;
        lens[1] = 11'd2047;
        lens[2] = 11'd1;
        lens[3] = LEN_W'($urandom_range(1023, 2));
        lens[4] = 11'd1024;
        lens[5] = LEN_W'($urandom_range(64, 2));
        for (int p = 0; p < 6; p++)
        begin
            wait (sum_q.size() == 0);
            @(negedge clk);
            repeat (1100) @(negedge clk);
            write_length(lens[p]);
            repeat (1100) @(negedge clk);
            tx_pct = (p < 2) ? 34 : (p < 4) ? 65 : 0;
            rx_pct = (p < 2) ? 65 : (p < 4) ? 34 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 1 && n == 20)
                    hold_req = 400;
                if (p == 1 && n == 60)
                begin
                    item_valid <= 1'b0;
                    wait (sum_q.size() == 0);
                    @(negedge clk);
                end
                send_word(random_word());
            end
            item_valid <= 1'b0;
        end

        wait (sum_q.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
